[design/gdc_pkg.sv]
// Shared constants, types and helper functions of the grid divergence and curl block.
`default_nettype none

package gdc_pkg;

  // Grid geometry
  localparam int GRID_DIM   = 32;
  localparam int CELL_W     = $clog2(GRID_DIM);
  localparam int ADDR_W     = 3 * CELL_W;
  localparam int CELLS      = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int SIZE_W     = 6;

  // Arithmetic widths
  localparam int COMP_W     = 32;
  localparam int DIFF_W     = COMP_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int FRAC_SHIFT = 17;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;
  localparam int ACC_W      = TERM_W + 2;

  // Sequencer
  localparam int N_NEIGH    = 6;
  localparam int NB_W       = $clog2(N_NEIGH);
  localparam int N_TERMS    = 9;
  localparam int STEP_W     = $clog2(N_TERMS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(GRID_DIM);
  localparam logic [COMP_W-1:0] INV_RESET  = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_INV_X,
    REG_INV_Y,
    REG_INV_Z
  } reg_idx_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [1:0] {
    ACC_DIV,
    ACC_CURL_X,
    ACC_CURL_Y,
    ACC_CURL_Z
  } acc_sel_t;

  typedef struct packed {
    axis_t    axis;   // axis of the difference
    axis_t    comp;   // field component that is differenced
    acc_sel_t acc;    // destination sum
    logic     neg;    // subtract instead of add
  } step_ctl_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  // Term schedule: three divergence terms, then two per curl component.
  function automatic step_ctl_t step_ctl(input logic [STEP_W-1:0] step);
    step_ctl_t c;
    c = '{axis: AX_X, comp: AX_X, acc: ACC_DIV, neg: 1'b0};
    case (step)
      4'd0:    c = '{axis: AX_X, comp: AX_X, acc: ACC_DIV,    neg: 1'b0};
      4'd1:    c = '{axis: AX_Y, comp: AX_Y, acc: ACC_DIV,    neg: 1'b0};
      4'd2:    c = '{axis: AX_Z, comp: AX_Z, acc: ACC_DIV,    neg: 1'b0};
      4'd3:    c = '{axis: AX_Y, comp: AX_Z, acc: ACC_CURL_X, neg: 1'b0};
      4'd4:    c = '{axis: AX_Z, comp: AX_Y, acc: ACC_CURL_X, neg: 1'b1};
      4'd5:    c = '{axis: AX_Z, comp: AX_X, acc: ACC_CURL_Y, neg: 1'b0};
      4'd6:    c = '{axis: AX_X, comp: AX_Z, acc: ACC_CURL_Y, neg: 1'b1};
      4'd7:    c = '{axis: AX_X, comp: AX_Y, acc: ACC_CURL_Z, neg: 1'b0};
      4'd8:    c = '{axis: AX_Y, comp: AX_X, acc: ACC_CURL_Z, neg: 1'b1};
      default: c = '{axis: AX_X, comp: AX_X, acc: ACC_DIV,    neg: 1'b0};
    endcase
    return c;
  endfunction

  // Clip a wide signed sum to the signed 32-bit range.
  function automatic logic signed [COMP_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(33'sh0_7FFF_FFFF));
    lo = ACC_W'(signed'(33'sh1_8000_0000));
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[COMP_W-1:0];
  endfunction

  // Effective grid size: zero acts as one, oversize acts as the full grid.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return SIZE_W'(1);
    end else if (s > SIZE_W'(GRID_DIM)) begin
      return SIZE_W'(GRID_DIM);
    end
    return s;
  endfunction

  // Saturate a cell index to the last point in use.
  function automatic logic [CELL_W-1:0] clamp_cell(input logic [CELL_W-1:0] c,
                                                   input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] last;
    last = n - SIZE_W'(1);
    if (SIZE_W'(c) >= n) begin
      return last[CELL_W-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/gdc_if.sv]
// Handshake channel interfaces for items, results and configuration writes.
`default_nettype none

interface gdc_in_if import gdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic [CELL_W-1:0]        cell_z;
  logic signed [COMP_W-1:0] value_x;
  logic signed [COMP_W-1:0] value_y;
  logic signed [COMP_W-1:0] value_z;

  modport source (output valid, kind, cell_x, cell_y, cell_z, value_x, value_y, value_z,
                  input ready);
  modport sink   (input valid, kind, cell_x, cell_y, cell_z, value_x, value_y, value_z,
                  output ready);
endinterface

interface gdc_out_if import gdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] divergence;
  logic signed [COMP_W-1:0] curl_x;
  logic signed [COMP_W-1:0] curl_y;
  logic signed [COMP_W-1:0] curl_z;

  modport source (output valid, divergence, curl_x, curl_y, curl_z, input ready);
  modport sink   (input valid, divergence, curl_x, curl_y, curl_z, output ready);
endinterface

interface gdc_cfg_if import gdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/grid_divergence_curl_stencil.sv]
// Top level: 3D vector grid with central-difference divergence and curl.
//
// Channels: in_ch takes items (write or query), out_ch returns one result beat
// per query, cfg_ch writes the six registers (sizes and reciprocal spacings);
// cfg_ch is always ready. A beat moves on a clock edge where valid and ready
// are both high.
// A write beat stores the vector in the same cycle it is taken; in_ch.ready
// stays high, so writes can be taken back to back.
// A query walks the six neighbors through the single read port of the grid
// memory (the registered read overlaps the first term), then runs the nine
// difference terms one per cycle through one shared 33x33 multiplier with a
// product register and an accumulate stage, then a drain state; the output
// state then loads the result register and raises out_ch.valid, and only
// then is the next item taken.
// in_ch.ready is low for the whole query. The result register parts the two
// sides: new items are taken while a result waits; only a following query
// holds at its final load until the receiver drains the previous result.
// Reset clears the sequencer, the output valid and the configuration to
// size 32 and spacing 1.0. The grid memory is not cleared: a cell must be
// written before a query reads it.
`default_nettype none

module grid_divergence_curl_stencil import gdc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  gdc_in_if.sink    in_ch,
  gdc_out_if.source out_ch,
  gdc_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [COMP_W-1:0] inv_x_r, inv_y_r, inv_z_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      inv_x_r  <= INV_RESET;
      inv_y_r  <= INV_RESET;
      inv_z_r  <= INV_RESET;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_SIZE_X: size_x_r <= cfg_ch.data[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= cfg_ch.data[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= cfg_ch.data[SIZE_W-1:0];
        REG_INV_X:  inv_x_r  <= cfg_ch.data[COMP_W-1:0];
        REG_INV_Y:  inv_y_r  <= cfg_ch.data[COMP_W-1:0];
        REG_INV_Z:  inv_z_r  <= cfg_ch.data[COMP_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Input cell clamping and neighbor indexes
  logic [SIZE_W-1:0] nx, ny, nz;
  logic [CELL_W-1:0] ci, cj, ck;
  logic [CELL_W-1:0] il_nxt, ih_nxt, jl_nxt, jh_nxt, kl_nxt, kh_nxt;

  assign nx = eff_size(size_x_r);
  assign ny = eff_size(size_y_r);
  assign nz = eff_size(size_z_r);
  assign ci = clamp_cell(in_ch.cell_x, nx);
  assign cj = clamp_cell(in_ch.cell_y, ny);
  assign ck = clamp_cell(in_ch.cell_z, nz);

  // Step one point down and one up along each axis, holding at the edges.
  always_comb begin
    il_nxt = (ci == '0) ? ci : ci - CELL_W'(1);
    jl_nxt = (cj == '0) ? cj : cj - CELL_W'(1);
    kl_nxt = (ck == '0) ? ck : ck - CELL_W'(1);
    ih_nxt = ((SIZE_W'(ci) + SIZE_W'(1)) < nx) ? ci + CELL_W'(1) : ci;
    jh_nxt = ((SIZE_W'(cj) + SIZE_W'(1)) < ny) ? cj + CELL_W'(1) : cj;
    kh_nxt = ((SIZE_W'(ck) + SIZE_W'(1)) < nz) ? ck + CELL_W'(1) : ck;
  end

  logic [CELL_W-1:0] i_r, j_r, k_r, il_r, ih_r, jl_r, jh_r, kl_r, kh_r;

  // Sequencer
  state_t state_r, state_nxt;
  logic [NB_W-1:0]   rd_cnt_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;

  logic in_fire, is_query, start_query, rd_issue, calc_issue, out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_query    = (in_ch.kind == KIND_QUERY);

  always_comb begin
    state_nxt   = state_r;
    start_query = 1'b0;
    rd_issue    = 1'b0;
    calc_issue  = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          start_query = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        rd_issue = 1'b1;
        if (rd_cnt_r == NB_W'(N_NEIGH - 1)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        calc_issue = 1'b1;
        if (step_r == STEP_W'(N_TERMS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      step_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_query) begin
        rd_cnt_r <= '0;
        step_r   <= '0;
      end else begin
        if (rd_issue) begin
          rd_cnt_r <= rd_cnt_r + NB_W'(1);
        end
        if (calc_issue) begin
          step_r <= step_r + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      i_r  <= ci;
      j_r  <= cj;
      k_r  <= ck;
      il_r <= il_nxt;
      ih_r <= ih_nxt;
      jl_r <= jl_nxt;
      jh_r <= jh_nxt;
      kl_r <= kl_nxt;
      kh_r <= kh_nxt;
    end
  end

  // Grid memory: one write port (write items), one registered read port.
  vec_t              mem [CELLS];
  vec_t              rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  vec_t              wr_data;

  assign mem_we  = in_fire && !is_query;
  assign wr_addr = {ci, cj, ck};
  assign wr_data = '{x: in_ch.value_x, y: in_ch.value_y, z: in_ch.value_z};

  // Neighbor order: low/high along x, then y, then z.
  always_comb begin
    case (rd_cnt_r[NB_W-1:1])
      2'd0:    rd_addr = {rd_cnt_r[0] ? ih_r : il_r, j_r, k_r};
      2'd1:    rd_addr = {i_r, rd_cnt_r[0] ? jh_r : jl_r, k_r};
      default: rd_addr = {i_r, j_r, rd_cnt_r[0] ? kh_r : kl_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Capture neighbors: hold the low one, store high minus low per axis.
  logic            rd_vld_r;
  logic [NB_W-1:0] rd_idx_r;
  vec_t            lo_r;
  logic signed [DIFF_W-1:0] dif_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_issue;
    end
    rd_idx_r <= rd_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!rd_idx_r[0]) begin
        lo_r <= rd_data_r;
      end else begin
        dif_r[rd_idx_r[NB_W-1:1]][AX_X] <= DIFF_W'(rd_data_r.x) - DIFF_W'(lo_r.x);
        dif_r[rd_idx_r[NB_W-1:1]][AX_Y] <= DIFF_W'(rd_data_r.y) - DIFF_W'(lo_r.y);
        dif_r[rd_idx_r[NB_W-1:1]][AX_Z] <= DIFF_W'(rd_data_r.z) - DIFF_W'(lo_r.z);
      end
    end
  end

  // Shared multiplier: one term per cycle, product registered.
  step_ctl_t                ctl;
  logic [COMP_W-1:0]        inv_sel;
  logic signed [DIFF_W-1:0] dif_sel;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic                     mv_r;
  step_ctl_t                mctl_r;

  assign ctl     = step_ctl(step_r);
  assign dif_sel = dif_r[ctl.axis][ctl.comp];

  always_comb begin
    case (ctl.axis)
      AX_X:    inv_sel = inv_x_r;
      AX_Y:    inv_sel = inv_y_r;
      AX_Z:    inv_sel = inv_z_r;
      default: inv_sel = inv_x_r;
    endcase
  end

  assign prod_nxt = PROD_W'(dif_sel) * PROD_W'(signed'({1'b0, inv_sel}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= calc_issue;
    end
    prod_r <= prod_nxt;
    mctl_r <= ctl;
  end

  // Accumulate: arithmetic shift floors the scaled and halved product.
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  acc_r [4];

  assign term     = prod_r[PROD_W-1:FRAC_SHIFT];
  assign term_ext = ACC_W'(term);

  always_ff @(posedge clk) begin
    if (start_query) begin
      for (int a = 0; a < 4; a++) begin
        acc_r[a] <= '0;
      end
    end else if (mv_r) begin
      if (mctl_r.neg) begin
        acc_r[mctl_r.acc] <= acc_r[mctl_r.acc] - term_ext;
      end else begin
        acc_r[mctl_r.acc] <= acc_r[mctl_r.acc] + term_ext;
      end
    end
  end

  // Result register
  logic signed [COMP_W-1:0] div_r, cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      div_r <= sat32(acc_r[ACC_DIV]);
      cx_r  <= sat32(acc_r[ACC_CURL_X]);
      cy_r  <= sat32(acc_r[ACC_CURL_Y]);
      cz_r  <= sat32(acc_r[ACC_CURL_Z]);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.divergence = div_r;
  assign out_ch.curl_x     = cx_r;
  assign out_ch.curl_y     = cy_r;
  assign out_ch.curl_z     = cz_r;

endmodule

`default_nettype wire

[tb/tb_grid_divergence_curl_stencil.sv]
// Self-checking testbench for the grid divergence and curl stencil block.
`timescale 1ns / 1ps

module tb_grid_divergence_curl_stencil;
  import gdc_pkg::*;

  // Stall rate on both sides, in percent of cycles.
  localparam int IDLE_PCT     = 17;
  // Long receiver hold-off that lets the block back up into its input.
  localparam int HOLD_CYCLES  = 300;
  // Extra cycles after the last result before touching the registers.
  localparam int DRAIN_CYCLES = 40;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int HOLD_PHASE   = 2;
  localparam int CALM_PHASE   = 5;
  localparam int PRINT_LIMIT  = 25;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Register indexes past the last real register; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  localparam logic signed [COMP_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COMP_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [2*COMP_W+1:0] wide_t;

  typedef struct packed {
    logic                     kind;
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_y;
    logic [CELL_W-1:0]        cell_z;
    logic signed [COMP_W-1:0] value_x;
    logic signed [COMP_W-1:0] value_y;
    logic signed [COMP_W-1:0] value_z;
  } grid_op_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] divergence;
    logic signed [COMP_W-1:0] curl_x;
    logic signed [COMP_W-1:0] curl_y;
    logic signed [COMP_W-1:0] curl_z;
  } div_curl_t;

  // Slots of the six axis neighbors of a cell.
  typedef enum int {NB_LO_X, NB_HI_X, NB_LO_Y, NB_HI_Y, NB_LO_Z, NB_HI_Z} nb_slot_t;
  typedef logic [N_NEIGH-1:0][ADDR_W-1:0] nb_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gdc_in_if  in_ch ();
  gdc_out_if out_ch ();
  gdc_cfg_if cfg_ch ();

  // Testbench-side drive registers; all inputs are known from time zero.
  logic                  drv_valid = 1'b0;
  grid_op_t              drv_item  = '0;
  logic                  rx_ready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  assign in_ch.valid   = drv_valid;
  assign in_ch.kind    = drv_item.kind;
  assign in_ch.cell_x  = drv_item.cell_x;
  assign in_ch.cell_y  = drv_item.cell_y;
  assign in_ch.cell_z  = drv_item.cell_z;
  assign in_ch.value_x = drv_item.value_x;
  assign in_ch.value_y = drv_item.value_y;
  assign in_ch.value_z = drv_item.value_z;
  assign out_ch.ready  = rx_ready;
  assign cfg_ch.valid  = cfg_valid;
  assign cfg_ch.index  = cfg_index;
  assign cfg_ch.data   = cfg_data;

  grid_divergence_curl_stencil u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the configuration registers, updated on each accepted write beat.
  logic [SIZE_W-1:0] span_x = SIZE_RESET;
  logic [SIZE_W-1:0] span_y = SIZE_RESET;
  logic [SIZE_W-1:0] span_z = SIZE_RESET;
  logic [COMP_W-1:0] inv_x  = INV_RESET;
  logic [COMP_W-1:0] inv_y  = INV_RESET;
  logic [COMP_W-1:0] inv_z  = INV_RESET;

  // Shadow of the grid memory, plus the set of cells the stimulus has stored.
  logic signed [COMP_W-1:0] grid_x [CELLS];
  logic signed [COMP_W-1:0] grid_y [CELLS];
  logic signed [COMP_W-1:0] grid_z [CELLS];
  bit                       grid_filled [CELLS];

  grid_op_t  grid_ops [$];  // items still to be offered on in_ch
  div_curl_t awaited [$];   // predicted results, oldest first

  logic calm      = 1'b0;   // no random idling on either side
  logic want_hold = 1'b0;   // ask the receiver for its long hold-off

  int mismatches     = 0;
  int beats_in       = 0;
  int stores_taken   = 0;
  int queries_taken  = 0;
  int results_seen   = 0;
  int configs_run    = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stencil prediction
  // ---------------------------------------------------------------------------

  // Size register as the block uses it: zero means one, oversize means full.
  function automatic int effective_span(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > GRID_DIM) return GRID_DIM;
    return int'(s);
  endfunction

  // Saturate an index to the last point in use.
  function automatic int clip_index(input logic [CELL_W-1:0] c, input int n);
    return (int'(c) >= n) ? n - 1 : int'(c);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y, input int z);
    return ADDR_W'((x * GRID_DIM + y) * GRID_DIM + z);
  endfunction

  // Address that a write beat lands on after index clamping.
  function automatic logic [ADDR_W-1:0] home_addr(input logic [CELL_W-1:0] cx,
                                                  input logic [CELL_W-1:0] cy,
                                                  input logic [CELL_W-1:0] cz);
    return cell_addr(clip_index(cx, effective_span(span_x)),
                     clip_index(cy, effective_span(span_y)),
                     clip_index(cz, effective_span(span_z)));
  endfunction

  // Six axis neighbors of a cell; at an edge the neighbor folds onto the cell.
  function automatic nb_set_t neighbor_addrs(input logic [CELL_W-1:0] cx,
                                             input logic [CELL_W-1:0] cy,
                                             input logic [CELL_W-1:0] cz);
    int nx, ny, nz, i, j, k;
    nb_set_t nb;
    nx = effective_span(span_x);
    ny = effective_span(span_y);
    nz = effective_span(span_z);
    i  = clip_index(cx, nx);
    j  = clip_index(cy, ny);
    k  = clip_index(cz, nz);
    nb[NB_LO_X] = cell_addr((i > 0) ? i - 1 : i, j, k);
    nb[NB_HI_X] = cell_addr((i + 1 < nx) ? i + 1 : i, j, k);
    nb[NB_LO_Y] = cell_addr(i, (j > 0) ? j - 1 : j, k);
    nb[NB_HI_Y] = cell_addr(i, (j + 1 < ny) ? j + 1 : j, k);
    nb[NB_LO_Z] = cell_addr(i, j, (k > 0) ? k - 1 : k);
    nb[NB_HI_Z] = cell_addr(i, j, (k + 1 < nz) ? k + 1 : k);
    return nb;
  endfunction

  // floor(d * inv / 2^17): drop the reciprocal's fraction and halve.
  function automatic wide_t scaled_half(input logic signed [COMP_W:0] d,
                                        input logic [COMP_W-1:0] inv);
    wide_t p;
    p = d * $signed({1'b0, inv});
    return p >>> FRAC_SHIFT;
  endfunction

  function automatic logic signed [COMP_W-1:0] clip32(input wide_t v);
    if (v > wide_t'(Q_MAX)) return Q_MAX;
    if (v < wide_t'(Q_MIN)) return Q_MIN;
    return v[COMP_W-1:0];
  endfunction

  function automatic div_curl_t stencil_at(input grid_op_t op);
    nb_set_t nb;
    logic signed [COMP_W:0] dx_fx, dx_fy, dx_fz, dy_fx, dy_fy, dy_fz, dz_fx, dz_fy, dz_fz;
    wide_t div_s, cx_s, cy_s, cz_s;
    div_curl_t r;
    nb = neighbor_addrs(op.cell_x, op.cell_y, op.cell_z);
    // Exact 33-bit differences across each axis.
    dx_fx = grid_x[nb[NB_HI_X]] - grid_x[nb[NB_LO_X]];
    dx_fy = grid_y[nb[NB_HI_X]] - grid_y[nb[NB_LO_X]];
    dx_fz = grid_z[nb[NB_HI_X]] - grid_z[nb[NB_LO_X]];
    dy_fx = grid_x[nb[NB_HI_Y]] - grid_x[nb[NB_LO_Y]];
    dy_fy = grid_y[nb[NB_HI_Y]] - grid_y[nb[NB_LO_Y]];
    dy_fz = grid_z[nb[NB_HI_Y]] - grid_z[nb[NB_LO_Y]];
    dz_fx = grid_x[nb[NB_HI_Z]] - grid_x[nb[NB_LO_Z]];
    dz_fy = grid_y[nb[NB_HI_Z]] - grid_y[nb[NB_LO_Z]];
    dz_fz = grid_z[nb[NB_HI_Z]] - grid_z[nb[NB_LO_Z]];
    div_s = scaled_half(dx_fx, inv_x) + scaled_half(dy_fy, inv_y) + scaled_half(dz_fz, inv_z);
    cx_s  = scaled_half(dy_fz, inv_y) - scaled_half(dz_fy, inv_z);
    cy_s  = scaled_half(dz_fx, inv_z) - scaled_half(dx_fz, inv_x);
    cz_s  = scaled_half(dx_fy, inv_x) - scaled_half(dy_fx, inv_y);
    r.divergence = clip32(div_s);
    r.curl_x     = clip32(cx_s);
    r.curl_y     = clip32(cy_s);
    r.curl_z     = clip32(cz_s);
    return r;
  endfunction

  // Update the grid shadow or queue the predicted result for one accepted beat.
  task automatic apply_item(input grid_op_t op);
    logic [ADDR_W-1:0] a;
    if (op.kind == KIND_WRITE) begin
      a = home_addr(op.cell_x, op.cell_y, op.cell_z);
      grid_x[a] = op.value_x;
      grid_y[a] = op.value_y;
      grid_z[a] = op.value_z;
      stores_taken++;
    end else begin
      awaited.push_back(stencil_at(op));
      queries_taken++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration shadow
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      span_x <= SIZE_RESET;
      span_y <= SIZE_RESET;
      span_z <= SIZE_RESET;
      inv_x  <= INV_RESET;
      inv_y  <= INV_RESET;
      inv_z  <= INV_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_SIZE_X: span_x <= cfg_ch.data[SIZE_W-1:0];
        REG_SIZE_Y: span_y <= cfg_ch.data[SIZE_W-1:0];
        REG_SIZE_Z: span_z <= cfg_ch.data[SIZE_W-1:0];
        REG_INV_X:  inv_x  <= cfg_ch.data;
        REG_INV_Y:  inv_y  <= cfg_ch.data;
        REG_INV_Z:  inv_z  <= cfg_ch.data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: offer items from grid_ops, predict on every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      // drv_item still holds the beat the block saw at this edge.
      if (in_ch.valid && in_ch.ready) begin
        apply_item(drv_item);
        beats_in++;
      end
      // Hold a beat that was not taken; otherwise load the next one or idle.
      if (!in_ch.valid || in_ch.ready) begin
        if (grid_ops.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          drv_item  <= grid_ops.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rx_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      rx_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    div_curl_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d arrived with nothing predicted",
                                results_seen));
      end else begin
        want = awaited.pop_front();
        if (out_ch.divergence !== want.divergence)
          flag_mismatch($sformatf("result %0d divergence got %h want %h",
                                  results_seen, out_ch.divergence, want.divergence));
        if (out_ch.curl_x !== want.curl_x)
          flag_mismatch($sformatf("result %0d curl_x got %h want %h",
                                  results_seen, out_ch.curl_x, want.curl_x));
        if (out_ch.curl_y !== want.curl_y)
          flag_mismatch($sformatf("result %0d curl_y got %h want %h",
                                  results_seen, out_ch.curl_y, want.curl_y));
        if (out_ch.curl_z !== want.curl_z)
          flag_mismatch($sformatf("result %0d curl_z got %h want %h",
                                  results_seen, out_ch.curl_z, want.curl_z));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Component values: rails, zero, small values that stay clear of saturation,
  // and full random words.
  function automatic logic signed [COMP_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3, 4, 5: return $signed($urandom_range(32'h000F_FFFF, 0)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Cell index: mostly within or just past the points in use, sometimes anywhere.
  function automatic logic [CELL_W-1:0] pick_cell(input int n);
    if ($urandom_range(9) < 7) return CELL_W'($urandom_range((n < GRID_DIM) ? n : n - 1, 0));
    return CELL_W'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(19))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(GRID_DIM);
      3:       return SIZE_W'(GRID_DIM + 1);
      4:       return '1;
      5:       return SIZE_W'($urandom_range(63, GRID_DIM + 1));
      6, 7:    return SIZE_W'($urandom_range(GRID_DIM - 1, 7));
      default: return SIZE_W'($urandom_range(6, 2));
    endcase
  endfunction

  function automatic logic [COMP_W-1:0] pick_inv();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return COMP_W'(1);
      3:       return INV_RESET;
      4, 5:    return $urandom;
      default: return $urandom_range(32'h0004_0000, 32'h0000_4000);
    endcase
  endfunction

  task automatic push_write(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                            input logic [CELL_W-1:0] cz, input logic signed [COMP_W-1:0] vx,
                            input logic signed [COMP_W-1:0] vy,
                            input logic signed [COMP_W-1:0] vz);
    grid_op_t op;
    op.kind    = KIND_WRITE;
    op.cell_x  = cx;
    op.cell_y  = cy;
    op.cell_z  = cz;
    op.value_x = vx;
    op.value_y = vy;
    op.value_z = vz;
    grid_filled[home_addr(cx, cy, cz)] = 1'b1;
    grid_ops.push_back(op);
  endtask

  // Queue a query, storing first any neighbor it reads that was never written.
  task automatic push_query(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                            input logic [CELL_W-1:0] cz);
    nb_set_t nb;
    grid_op_t op;
    logic [CELL_W-1:0] fx, fy, fz;
    nb = neighbor_addrs(cx, cy, cz);
    for (int n = 0; n < N_NEIGH; n++) begin
      if (!grid_filled[nb[n]]) begin
        {fx, fy, fz} = nb[n];
        push_write(fx, fy, fz, pick_value(), pick_value(), pick_value());
      end
    end
    op.kind    = KIND_QUERY;
    op.cell_x  = cx;
    op.cell_y  = cy;
    op.cell_z  = cz;
    // Value fields are don't-care on a query; toggle them anyway.
    op.value_x = $urandom;
    op.value_y = $urandom;
    op.value_z = $urandom;
    grid_ops.push_back(op);
  endtask

  // One write beat; valid stays high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all six registers; size writes carry junk above the 6-bit field.
  task automatic set_config(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                            input logic [SIZE_W-1:0] sz, input logic [COMP_W-1:0] ix,
                            input logic [COMP_W-1:0] iy, input logic [COMP_W-1:0] iz,
                            input bit spare);
    write_reg(REG_SIZE_X, ($urandom & ~32'h3F) | sx);
    write_reg(REG_SIZE_Y, ($urandom & ~32'h3F) | sy);
    write_reg(REG_SIZE_Z, ($urandom & ~32'h3F) | sz);
    write_reg(REG_INV_X, ix);
    write_reg(REG_INV_Y, iy);
    write_reg(REG_INV_Z, iz);
    if (spare) begin
      write_reg(SPARE_IDX_LO, $urandom);
      write_reg(SPARE_IDX_HI, $urandom);
    end
    cfg_valid <= 1'b0;
    // Let the shadow registers settle before any item is generated.
    @(posedge clk);
    configs_run++;
  endtask

  // Drain: every item taken, every result back, then a few quiet cycles.
  task automatic settle();
    while (grid_ops.size() != 0 || in_ch.valid || awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: opposite rails around the low corner, then the high
    // corner and the middle.
    push_write(5'd0, 5'd0, 5'd0, Q_MAX, Q_MIN, '0);
    push_write(5'd1, 5'd0, 5'd0, Q_MIN, Q_MAX, -32'sd1);
    push_write(5'd0, 5'd1, 5'd0, Q_MAX, '0, Q_MIN);
    push_write(5'd0, 5'd0, 5'd1, Q_MIN, -32'sd1, Q_MAX);
    push_query(5'd0, 5'd0, 5'd0);
    push_write(5'd31, 5'd31, 5'd31, 32'sd65536, -32'sd65536, 32'sd1);
    push_query(5'd31, 5'd31, 5'd31);
    push_query(5'd15, 5'd16, 5'd17);
    settle();

    // Size zero, one past the grid and all ones; zero, full-scale and minimal
    // reciprocals; writes to unknown register indexes. Cells past the size clamp.
    set_config('0, SIZE_W'(GRID_DIM + 1), '1, '0, '1, COMP_W'(1), 1'b1);
    push_write(5'd31, 5'd31, 5'd31, Q_MIN, Q_MAX, Q_MIN);
    push_query(5'd20, 5'd0, 5'd31);
    push_query(5'd5, 5'd31, 5'd0);
    push_query(5'd0, 5'd12, 5'd30);
    settle();

    // Random phases, each under a fresh configuration.
    for (int p = 0; p < N_PHASES; p++) begin
      set_config(pick_size(), pick_size(), pick_size(), pick_inv(), pick_inv(), pick_inv(),
                 $urandom_range(3) == 0);
      calm = (p == CALM_PHASE);
      // Hold the receiver off while items keep coming, so the result register
      // fills and the next query backs up into the input.
      if (p == HOLD_PHASE) want_hold = 1'b1;
      // Count every queued beat, neighbor fills included, against the phase budget.
      while (grid_ops.size() < PHASE_ITEMS) begin
        if ($urandom_range(99) < 45) begin
          push_query(pick_cell(effective_span(span_x)), pick_cell(effective_span(span_y)),
                     pick_cell(effective_span(span_z)));
        end else begin
          push_write(pick_cell(effective_span(span_x)), pick_cell(effective_span(span_y)),
                     pick_cell(effective_span(span_z)), pick_value(), pick_value(),
                     pick_value());
        end
      end
      settle();
    end
    calm = 1'b0;

    $display("Ran %0d input beats (%0d stores, %0d stencil queries) under %0d configurations.",
             beats_in, stores_taken, queries_taken, configs_run);
    $display("Checked %0d result beats; %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d predicted results still outstanding.", awaited.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
design/gdc_pkg.sv
design/gdc_if.sv
design/grid_divergence_curl_stencil.sv
tb/tb_grid_divergence_curl_stencil.sv
